// ----- design/bnms_pkg.sv -----
// shared types, constants and helpers for the box nms engine
// no dependencies
package bnms_pkg;

	localparam int MAX_BOXES = 64;
	localparam int IDX_W     = $clog2(MAX_BOXES);
	localparam int CNT_W     = $clog2(MAX_BOXES + 1);
	localparam int RANK_W    = 6;
	localparam int Q16_W     = 17;
	localparam int EDGE_W    = 19;
	localparam int AREA_W    = 33;
	localparam int UNI_W     = 34;
	localparam int MUL_A_W   = 34;
	localparam int MUL_B_W   = 17;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int ADDR_W    = 3;

	localparam logic [Q16_W-1:0] Q16_ONE       = 17'h10000;
	localparam logic [Q16_W-1:0] SCORE_THR_RST = 17'd32768;
	localparam logic [Q16_W-1:0] OVL_THR_RST   = 17'd19661;

	// register index taken from paddr[2]
	localparam logic REG_SCORE_THR = 1'b0;
	localparam logic REG_OVL_THR   = 1'b1;

	typedef struct packed {
		logic [Q16_W-1:0] score;
		logic [Q16_W-1:0] left;
		logic [Q16_W-1:0] top;
		logic [Q16_W-1:0] right;
		logic [Q16_W-1:0] bottom;
	} box_t;

	localparam int BOX_W = $bits(box_t);

	typedef struct packed {
		logic done;
		logic suppress;
	} ovl_rsp_t;

	typedef enum logic [2:0] {
		OVL_IDLE,
		OVL_INTER,
		OVL_AREA_A,
		OVL_AREA_B,
		OVL_UNION,
		OVL_CMP
	} ovl_state_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_SC_NEXT,
		S_SC_RD,
		S_SC_CMP,
		S_SC_WR,
		S_NM_NEXT,
		S_NM_CUR,
		S_NM_J,
		S_NM_JLAT,
		S_NM_WAIT,
		S_EM_NEXT,
		S_EM_OUT,
		S_EMPTY,
		S_CLEAR
	} nms_state_t;

	function automatic logic [Q16_W-1:0] clamp_edge(input logic signed [EDGE_W-1:0] v);
		logic [Q16_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({2'b00, Q16_ONE})) begin
			r = Q16_ONE;
		end else begin
			r = v[Q16_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- design/bnms_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module bnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/bnms_overlap.sv -----
// iou overlap test stepped through a state sequence with one shared multiplier
// depends on bnms_pkg
module bnms_overlap (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  bnms_pkg::box_t            box_a,
	input  bnms_pkg::box_t            box_b,
	input  logic [bnms_pkg::Q16_W-1:0] thr,
	output bnms_pkg::ovl_rsp_t        rsp
);
	import bnms_pkg::*;

	ovl_state_t state_q, state_d;

	logic [Q16_W-1:0] iw_q, ih_q, wa_q, ha_q, wb_q, hb_q;
	logic [AREA_W-1:0] inter_q, area_a_q, area_b_q;
	logic [UNI_W-1:0] uni_q;

	logic [Q16_W-1:0] x0, x1, y0, y1, iw, ih;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;

	// intersection extents
	always_comb begin
		x0 = (box_a.left > box_b.left) ? box_a.left : box_b.left;
		x1 = (box_a.right < box_b.right) ? box_a.right : box_b.right;
		y0 = (box_a.top > box_b.top) ? box_a.top : box_b.top;
		y1 = (box_a.bottom < box_b.bottom) ? box_a.bottom : box_b.bottom;
		iw = (x1 > x0) ? x1 - x0 : '0;
		ih = (y1 > y0) ? y1 - y0 : '0;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			OVL_IDLE:   if (start) state_d = OVL_INTER;
			OVL_INTER:  state_d = OVL_AREA_A;
			OVL_AREA_A: state_d = OVL_AREA_B;
			OVL_AREA_B: state_d = OVL_UNION;
			OVL_UNION:  state_d = OVL_CMP;
			OVL_CMP:    state_d = OVL_IDLE;
			default:    state_d = OVL_IDLE;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			OVL_INTER: begin
				mul_a = MUL_A_W'(iw_q);
				mul_b = ih_q;
			end
			OVL_AREA_A: begin
				mul_a = MUL_A_W'(wa_q);
				mul_b = ha_q;
			end
			OVL_AREA_B: begin
				mul_a = MUL_A_W'(wb_q);
				mul_b = hb_q;
			end
			OVL_CMP: begin
				mul_a = uni_q;
				mul_b = thr;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	end

	always_comb begin
		rsp.done     = (state_q == OVL_CMP);
		rsp.suppress = (state_q == OVL_CMP) && (uni_q != '0) &&
			(MUL_P_W'({inter_q, 16'h0000}) > prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OVL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			OVL_IDLE: begin
				if (start) begin
					iw_q <= iw;
					ih_q <= ih;
					wa_q <= box_a.right - box_a.left;
					ha_q <= box_a.bottom - box_a.top;
					wb_q <= box_b.right - box_b.left;
					hb_q <= box_b.bottom - box_b.top;
				end
			end
			OVL_INTER:  inter_q <= prod[AREA_W-1:0];
			OVL_AREA_A: area_a_q <= prod[AREA_W-1:0];
			OVL_AREA_B: area_b_q <= prod[AREA_W-1:0];
			OVL_UNION:  uni_q <= UNI_W'(area_a_q) + UNI_W'(area_b_q) - UNI_W'(inter_q);
			default: begin
			end
		endcase
	end

endmodule

// ----- design/box_nms_engine.sv -----
// box nms engine top level: load, sort, suppression and emit sequencer
// depends on bnms_pkg, bnms_ram, bnms_overlap
//
// priors are taken one per cycle while busy is low; a prior is stored when its score
// reaches score_threshold and its clamped box is non-empty, up to 64 boxes, further
// passing priors are dropped and set overflowed. the request with final_prior high
// closes the frame: busy then rises and the engine sorts by a selection scan over the
// candidate ram (one ram read per compare), then runs greedy suppression where each
// pair test runs on one shared multiplier (at most n*(n-1)/2 pairs for n stored
// boxes), then emits the kept boxes one per result. results appear on one cycle each
// marked by strobe and cannot be held off; a frame with no kept box gives one result
// with found low. busy drops after the cleanup state that follows the result with
// last_box high. configuration writes are for idle time only.
module box_nms_engine (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request side
	input  logic        start,
	output logic        busy,
	input  logic [16:0] score,
	input  logic [18:0] left_edge,
	input  logic [18:0] top_edge,
	input  logic [18:0] right_edge,
	input  logic [18:0] bottom_edge,
	input  logic        final_prior,
	// result side
	output logic        strobe,
	output logic        found,
	output logic [5:0]  kept_rank,
	output logic [16:0] kept_score,
	output logic [16:0] kept_left,
	output logic [16:0] kept_top,
	output logic [16:0] kept_right,
	output logic [16:0] kept_bottom,
	output logic        overflowed,
	output logic        last_box
);
	import bnms_pkg::*;

	nms_state_t state_q, state_d;

	// thresholds
	logic [Q16_W-1:0] score_thr_q, ovl_thr_q;

	// frame bookkeeping
	logic [CNT_W-1:0] count_q, rank_q, scan_q, j_q, total_q, emit_q;
	logic             ovf_q, have_q, keep_q;
	logic [MAX_BOXES-1:0] kept_q, taken_q;
	logic [IDX_W-1:0] best_idx_q;
	box_t             best_q, cur_q;

	// request decode
	logic             accept, pass, full, cfg_wr;
	box_t             in_box;

	// ram ports
	logic             cand_we, sort_we;
	logic [IDX_W-1:0] cand_raddr, sort_raddr;
	box_t             cand_rdata, sort_rdata;

	// overlap unit
	logic             ovl_start;
	ovl_rsp_t         ovl_rsp;

	logic             last_kept;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[2])
			REG_SCORE_THR: prdata = 32'(score_thr_q);
			REG_OVL_THR:   prdata = 32'(ovl_thr_q);
			default:       prdata = '0;
		endcase
	end

	assign accept = start && !busy;

	always_comb begin
		in_box.score  = score;
		in_box.left   = clamp_edge(left_edge);
		in_box.top    = clamp_edge(top_edge);
		in_box.right  = clamp_edge(right_edge);
		in_box.bottom = clamp_edge(bottom_edge);
		pass = (score >= score_thr_q) && (in_box.right > in_box.left) &&
			(in_box.bottom > in_box.top);
		full = (count_q == CNT_W'(MAX_BOXES));
	end

	assign cand_we    = accept && pass && !full;
	assign cand_raddr = scan_q[IDX_W-1:0];

	// arrival-order candidate store
	bnms_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_cand_ram (
		.clk   (clk),
		.we    (cand_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (in_box),
		.raddr (cand_raddr),
		.rdata (cand_rdata)
	);

	// score-sorted store, address is the rank
	bnms_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_sort_ram (
		.clk   (clk),
		.we    (sort_we),
		.waddr (rank_q[IDX_W-1:0]),
		.wdata (best_q),
		.raddr (sort_raddr),
		.rdata (sort_rdata)
	);

	bnms_overlap u_overlap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ovl_start),
		.box_a  (cur_q),
		.box_b  (sort_rdata),
		.thr    (ovl_thr_q),
		.rsp    (ovl_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: if (accept && final_prior) state_d = S_SC_NEXT;
			S_SC_NEXT: state_d = (rank_q == count_q) ? S_NM_NEXT : S_SC_RD;
			S_SC_RD:   state_d = (scan_q == count_q) ? S_SC_WR : S_SC_CMP;
			S_SC_CMP:  state_d = S_SC_RD;
			S_SC_WR:   state_d = S_SC_NEXT;
			S_NM_NEXT: state_d = (rank_q == count_q) ? S_EM_NEXT : S_NM_CUR;
			S_NM_CUR:  state_d = S_NM_J;
			S_NM_J: begin
				priority if (j_q == rank_q || !keep_q) begin
					state_d = S_NM_NEXT;
				end else if (kept_q[j_q[IDX_W-1:0]]) begin
					state_d = S_NM_JLAT;
				end else begin
					state_d = S_NM_J;
				end
			end
			S_NM_JLAT: state_d = S_NM_WAIT;
			S_NM_WAIT: if (ovl_rsp.done) state_d = S_NM_J;
			S_EM_NEXT: begin
				priority if (total_q == '0) begin
					state_d = S_EMPTY;
				end else if (rank_q == count_q) begin
					state_d = S_CLEAR;
				end else if (kept_q[rank_q[IDX_W-1:0]]) begin
					state_d = S_EM_OUT;
				end else begin
					state_d = S_EM_NEXT;
				end
			end
			S_EM_OUT: state_d = last_kept ? S_CLEAR : S_EM_NEXT;
			S_EMPTY:  state_d = S_CLEAR;
			S_CLEAR:  state_d = S_LOAD;
			default:  state_d = S_LOAD;
		endcase
	end

	assign last_kept = (CNT_W'(emit_q + 1'b1) == total_q);

	// outputs and ram control
	always_comb begin
		busy       = (state_q != S_LOAD);
		sort_we    = (state_q == S_SC_WR);
		ovl_start  = (state_q == S_NM_JLAT);
		sort_raddr = (state_q == S_NM_J) ? j_q[IDX_W-1:0] : rank_q[IDX_W-1:0];
		strobe     = (state_q == S_EM_OUT) || (state_q == S_EMPTY);
		found      = (state_q == S_EM_OUT);
		overflowed = ovf_q;
		last_box   = (state_q == S_EMPTY) || ((state_q == S_EM_OUT) && last_kept);
		if (state_q == S_EM_OUT) begin
			kept_rank   = RANK_W'(rank_q);
			kept_score  = sort_rdata.score;
			kept_left   = sort_rdata.left;
			kept_top    = sort_rdata.top;
			kept_right  = sort_rdata.right;
			kept_bottom = sort_rdata.bottom;
		end else begin
			kept_rank   = '0;
			kept_score  = '0;
			kept_left   = '0;
			kept_top    = '0;
			kept_right  = '0;
			kept_bottom = '0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			score_thr_q <= SCORE_THR_RST;
			ovl_thr_q   <= OVL_THR_RST;
			count_q     <= '0;
			rank_q      <= '0;
			scan_q      <= '0;
			j_q         <= '0;
			total_q     <= '0;
			emit_q      <= '0;
			ovf_q       <= 1'b0;
			have_q      <= 1'b0;
			keep_q      <= 1'b0;
			kept_q      <= '0;
			taken_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_SCORE_THR: score_thr_q <= pwdata[Q16_W-1:0];
					REG_OVL_THR:   ovl_thr_q <= pwdata[Q16_W-1:0];
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_LOAD: begin
					if (cand_we) begin
						count_q <= count_q + 1'b1;
					end
					// passing prior with the store already full
					if (accept && pass && full) begin
						ovf_q <= 1'b1;
					end
					rank_q <= '0;
				end
				S_SC_NEXT: begin
					if (rank_q == count_q) begin
						rank_q  <= '0;
						total_q <= '0;
					end
					scan_q <= '0;
					have_q <= 1'b0;
				end
				S_SC_CMP: begin
					// strict compare keeps the earliest of equal scores
					if (!taken_q[scan_q[IDX_W-1:0]] &&
						(!have_q || cand_rdata.score > best_q.score)) begin
						have_q     <= 1'b1;
						best_idx_q <= scan_q[IDX_W-1:0];
					end
					scan_q <= scan_q + 1'b1;
				end
				S_SC_WR: begin
					taken_q[best_idx_q] <= 1'b1;
					rank_q <= rank_q + 1'b1;
				end
				S_NM_NEXT: begin
					if (rank_q == count_q) begin
						rank_q <= '0;
						emit_q <= '0;
					end
				end
				S_NM_CUR: begin
					keep_q <= 1'b1;
					j_q    <= '0;
				end
				S_NM_J: begin
					if (j_q == rank_q || !keep_q) begin
						kept_q[rank_q[IDX_W-1:0]] <= keep_q;
						if (keep_q) begin
							total_q <= total_q + 1'b1;
						end
						rank_q <= rank_q + 1'b1;
					end else if (!kept_q[j_q[IDX_W-1:0]]) begin
						j_q <= j_q + 1'b1;
					end
				end
				S_NM_WAIT: begin
					if (ovl_rsp.done) begin
						if (ovl_rsp.suppress) begin
							keep_q <= 1'b0;
						end
						j_q <= j_q + 1'b1;
					end
				end
				S_EM_NEXT: begin
					if (total_q != '0 && rank_q != count_q &&
						!kept_q[rank_q[IDX_W-1:0]]) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				S_EM_OUT: begin
					emit_q <= emit_q + 1'b1;
					rank_q <= rank_q + 1'b1;
				end
				S_CLEAR: begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					kept_q  <= '0;
					taken_q <= '0;
					rank_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_SC_CMP && !taken_q[scan_q[IDX_W-1:0]] &&
			(!have_q || cand_rdata.score > best_q.score)) begin
			best_q <= cand_rdata;
		end
		if (state_q == S_NM_CUR) begin
			cur_q <= sort_rdata;
		end
	end

endmodule

// ----- design/bnms_checker.sv -----
// port-level checks for the box nms engine, bound to the top level
// depends on box_nms_engine ports only
module bnms_props (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic final_prior,
	input logic strobe,
	input logic found,
	input logic last_box
);

	// results only come out while the frame is being processed
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("result while idle");

	// closing request starts processing
	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && final_prior |=> busy) else $error("no processing after last prior");

	// empty marker is always the single final result
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !found |-> last_box) else $error("empty marker not last");

	// nothing follows the last result and the engine frees up after cleanup
	a_last_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_box |=> !strobe) else $error("result after last");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_box |=> ##1 !busy) else $error("still busy after frame");

endmodule

bind box_nms_engine bnms_props u_bnms_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.final_prior (final_prior),
	.strobe      (strobe),
	.found       (found),
	.last_box    (last_box)
);

// ----- verif/bnms_checker.sv -----
`timescale 1ns / 100ps
// result checker for the box nms engine: follows register writes and requests,
// predicts the kept boxes of each frame and compares every strobed result
// depends on bnms_pkg
module bnms_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        start,
	input  logic        busy,
	input  logic [16:0] score,
	input  logic [18:0] left_edge,
	input  logic [18:0] top_edge,
	input  logic [18:0] right_edge,
	input  logic [18:0] bottom_edge,
	input  logic        final_prior,
	input  logic        strobe,
	input  logic        found,
	input  logic [5:0]  kept_rank,
	input  logic [16:0] kept_score,
	input  logic [16:0] kept_left,
	input  logic [16:0] kept_top,
	input  logic [16:0] kept_right,
	input  logic [16:0] kept_bottom,
	input  logic        overflowed,
	input  logic        last_box,
	output int          fails,
	output int          pending,
	output int          results_seen
);
	import bnms_pkg::*;

	typedef struct {
		logic        found;
		logic [5:0]  rank;
		logic [16:0] score;
		logic [16:0] left;
		logic [16:0] top;
		logic [16:0] right;
		logic [16:0] bottom;
		logic        ovf;
		logic        last;
	} kept_box_t;

	kept_box_t   kept_q[$];
	logic [16:0] min_score, iou_limit;
	logic [16:0] cand_score[MAX_BOXES];
	logic [16:0] cand_l[MAX_BOXES], cand_t[MAX_BOXES], cand_r[MAX_BOXES], cand_b[MAX_BOXES];
	int          cand_count;
	logic        dropped;

	function automatic logic [16:0] clip_q16(logic signed [18:0] v);
		if (v < 0) return '0;
		if (v > 19'sd65536) return Q16_ONE;
		return v[16:0];
	endfunction

	function automatic longint unsigned area_of(int i);
		return longint'(cand_r[i] - cand_l[i]) * longint'(cand_b[i] - cand_t[i]);
	endfunction

	function automatic bit too_close(int a, int b);
		longint unsigned x0, y0, x1, y1, iw, ih, inter, uni;
		x0 = (cand_l[a] > cand_l[b]) ? cand_l[a] : cand_l[b];
		y0 = (cand_t[a] > cand_t[b]) ? cand_t[a] : cand_t[b];
		x1 = (cand_r[a] < cand_r[b]) ? cand_r[a] : cand_r[b];
		y1 = (cand_b[a] < cand_b[b]) ? cand_b[a] : cand_b[b];
		iw = (x1 > x0) ? x1 - x0 : 0;
		ih = (y1 > y0) ? y1 - y0 : 0;
		inter = iw * ih;
		uni = area_of(a) + area_of(b) - inter;
		if (uni == 0) return 0;
		return inter * 65536 > longint'(iou_limit) * uni;
	endfunction

	// stable sort by falling score, greedy suppression, then queue the kept boxes or the empty marker
	task automatic close_frame();
		int        order[MAX_BOXES];
		bit        keep[MAX_BOXES];
		int        cur, j, total, sent;
		kept_box_t r;
		total = 0;
		for (int i = 0; i < cand_count; i++) begin
			j = i;
			while (j > 0 && cand_score[order[j-1]] < cand_score[i]) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		for (int i = 0; i < cand_count; i++) begin
			keep[order[i]] = 1;
			for (j = 0; j < i; j++)
				if (keep[order[j]] && too_close(order[i], order[j])) keep[order[i]] = 0;
			if (keep[order[i]]) total++;
		end
		if (total == 0) begin
			r = '{found: 0, rank: 0, score: 0, left: 0, top: 0, right: 0, bottom: 0,
				ovf: dropped, last: 1};
			kept_q = {kept_q, r};
		end else begin
			sent = 0;
			for (int i = 0; i < cand_count; i++) begin
				cur = order[i];
				if (!keep[cur]) continue;
				sent++;
				r = '{found: 1, rank: i[5:0], score: cand_score[cur], left: cand_l[cur],
					top: cand_t[cur], right: cand_r[cur], bottom: cand_b[cur],
					ovf: dropped, last: (sent == total)};
				kept_q = {kept_q, r};
			end
		end
		cand_count = 0;
		dropped = 0;
	endtask

	task automatic match_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [16:0] l, t, r, b;
		kept_box_t   e;
		if (!arst_n) begin
			min_score  <= SCORE_THR_RST;
			iou_limit  <= OVL_THR_RST;
			cand_count = 0;
			dropped    = 0;
			fails      = 0;
			results_seen = 0;
			kept_q.delete();
			pending    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_SCORE_THR) min_score <= pwdata[16:0];
				else iou_limit <= pwdata[16:0];
			end
			if (strobe) begin
				results_seen++;
				if (kept_q.size() == 0) begin
					$error("result with no request outstanding");
					fails++;
				end else begin
					e = kept_q.pop_front();
					match_field("found", e.found, found);
					match_field("kept_rank", e.rank, kept_rank);
					match_field("kept_score", e.score, kept_score);
					match_field("kept_left", e.left, kept_left);
					match_field("kept_top", e.top, kept_top);
					match_field("kept_right", e.right, kept_right);
					match_field("kept_bottom", e.bottom, kept_bottom);
					match_field("overflowed", e.ovf, overflowed);
					match_field("last_box", e.last, last_box);
				end
			end
			// request accepted at this edge
			if (start && !busy) begin
				l = clip_q16(left_edge);
				t = clip_q16(top_edge);
				r = clip_q16(right_edge);
				b = clip_q16(bottom_edge);
				if (score >= min_score && r > l && b > t) begin
					if (cand_count < MAX_BOXES) begin
						cand_score[cand_count] = score;
						cand_l[cand_count] = l;
						cand_t[cand_count] = t;
						cand_r[cand_count] = r;
						cand_b[cand_count] = b;
						cand_count++;
					end else begin
						dropped = 1;
					end
				end
				if (final_prior) close_frame();
			end
			pending = kept_q.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// top of the box nms engine testbench: clock, reset, register writes and frames of priors
// depends on bnms_pkg, box_nms_engine and bnms_checker
module testbench;
	import bnms_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 0;
	logic        busy;
	logic [16:0] score = '0;
	logic [18:0] left_edge = '0, top_edge = '0, right_edge = '0, bottom_edge = '0;
	logic        final_prior = 0;
	logic        strobe, found, overflowed, last_box;
	logic [5:0]  kept_rank;
	logic [16:0] kept_score, kept_left, kept_top, kept_right, kept_bottom;

	int fails, pending, results_seen;
	int priors_sent = 0, frames_sent = 0, settings_used = 0;
	int burst_left = 0;
	int cycle_count = 0;

	box_nms_engine u_dut (.*);

	bnms_checker u_checker (.*);

	always #2 clk = ~clk;

	// watchdog: ends the run as a failure if it hangs, with wide margin over a full 64-box frame
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 3000000) begin
			$display("tb: failure");
			$finish;
		end
	end

	// one request, held until the engine takes it; idle gaps fall between bursts
	task automatic send_prior(logic [16:0] s, logic [18:0] l, logic [18:0] t,
		logic [18:0] r, logic [18:0] b, logic fin);
		if (burst_left == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// mostly short bursts, sometimes a long unbroken stretch
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		start       <= 1;
		score       <= s;
		left_edge   <= l;
		top_edge    <= t;
		right_edge  <= r;
		bottom_edge <= b;
		final_prior <= fin;
		do @(posedge clk); while (busy);
		priors_sent++;
		if (fin) frames_sent++;
	endtask

	// wait for the frame in flight to drain, then let busy settle
	task automatic drain();
		start <= 0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	// apb write: setup cycle then access cycle, only while idle
	task automatic write_reg(logic idx, logic [16:0] val);
		drain();
		psel    <= 1;
		pwrite  <= 1;
		penable <= 0;
		paddr   <= {idx, 2'b00};
		pwdata  <= {15'd0, val};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic logic [18:0] near(int base, int spread);
		int v;
		// now and then a fully random code so every edge bit toggles
		if ($urandom_range(0, 7) == 0) return 19'($urandom);
		v = base + $urandom_range(0, 2 * spread) - spread;
		return 19'(v);
	endfunction

	// a frame of n priors clustered around a few centers so suppression has work to do
	task automatic random_frame(int n);
		int cx, cy, w, h;
		logic [16:0] s;
		for (int i = 0; i < n; i++) begin
			if (i == 0 || $urandom_range(0, 2) == 0) begin
				cx = $urandom_range(0, 65536);
				cy = $urandom_range(0, 65536);
				w  = $urandom_range(1, 20000);
				h  = $urandom_range(1, 20000);
			end
			if ($urandom_range(0, 7) == 0) s = 17'($urandom);
			else if ($urandom_range(0, 5) == 0) s = 17'd50000;  // score ties
			else s = 17'($urandom_range(0, 65536));
			send_prior(s, near(cx - w, 3000), near(cy - h, 3000), near(cx + w, 3000),
				near(cy + h, 3000), i == n - 1);
		end
	endtask

	initial begin
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset thresholds: score extremes, edge extremes, empty and inverted boxes
		send_prior(17'd0, 19'd100, 19'd100, 19'd9000, 19'd9000, 0);
		// most negative edge codes up to most positive
		send_prior(17'd65536, 19'h40000, 19'h40000, 19'h3FFFF, 19'h3FFFF, 0);
		send_prior(17'd65536, 19'd0, 19'd0, 19'd65536, 19'd65536, 0);  // duplicate tie
		send_prior(17'h1FFFF, 19'd1000, 19'd1000, 19'd3000, 19'd3000, 0);
		send_prior(17'd32768, 19'd40000, 19'd40000, 19'd50000, 19'd50000, 0);
		send_prior(17'd32767, 19'd10, 19'd10, 19'd20, 19'd20, 0);
		send_prior(17'd60000, 19'd5000, 19'd5000, 19'd5000, 19'd7000, 0);  // zero width
		send_prior(17'd60000, 19'd8000, 19'd8000, 19'd7000, 19'd9000, 0);  // inverted
		send_prior(17'd60000, 19'd70000, 19'd0, 19'd80000, 19'd10, 0);  // clamps flat
		send_prior(17'd40000, 19'd40000, 19'd40000, 19'd50000, 19'd50001, 1);
		// frame with nothing stored gives the empty marker
		send_prior(17'd100, 19'd0, 19'd0, 19'd10, 19'd10, 1);
		// single passing prior
		send_prior(17'd65535, 19'd1, 19'd2, 19'd3, 19'd4, 1);

		// any overlap suppresses, edge-touching boxes do not
		write_reg(REG_OVL_THR, 17'd0);
		write_reg(REG_SCORE_THR, 17'd0);
		send_prior(17'd0, 19'd0, 19'd0, 19'd100, 19'd100, 0);
		send_prior(17'd5, 19'd100, 19'd0, 19'd200, 19'd100, 0);
		send_prior(17'd9, 19'd50, 19'd50, 19'd150, 19'd150, 1);
		// identical boxes survive at full threshold
		write_reg(REG_OVL_THR, 17'd65536);
		write_reg(REG_SCORE_THR, 17'd65536);
		send_prior(17'd65536, 19'd0, 19'd0, 19'd65536, 19'd65536, 0);
		send_prior(17'd65536, 19'd0, 19'd0, 19'd65536, 19'd65536, 0);
		send_prior(17'd65535, 19'd0, 19'd0, 19'd65536, 19'd65536, 1);

		// store overflow: more priors than the engine holds
		write_reg(REG_SCORE_THR, 17'd0);
		write_reg(REG_OVL_THR, 17'd19661);
		random_frame(MAX_BOXES + 3);

		// random frames, mostly small, over a series of threshold settings
		while (priors_sent < 150) begin
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_SCORE_THR, ($urandom_range(0, 3) == 0) ? 17'd0
					: 17'($urandom_range(0, 65536)));
				write_reg(REG_OVL_THR, ($urandom_range(0, 4) == 0) ? 17'd65536
					: 17'($urandom_range(0, 65536)));
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
			random_frame(n);
		end

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d priors in %0d frames, %0d results, %0d register writes",
			priors_sent, frames_sent, results_seen, settings_used);
		if (fails == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- box_nms_engine.f -----
design/bnms_pkg.sv
design/bnms_ram.sv
design/bnms_overlap.sv
design/box_nms_engine.sv
design/bnms_checker.sv
verif/bnms_checker.sv
verif/testbench.sv
